/* sv/nnd_pkg.sv */
// Shared types and constants for the nearest-neighbor downscaler.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package nnd_pkg;

   localparam int PIXEL_BITS       = 32;
   localparam int DEFAULT_DIM_BITS = 16;
   localparam int CSR_INDEX_BITS   = 2;
   localparam int QUEUE_DEPTH      = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SOURCE_WIDTH     = 2'd0,
      CSR_SOURCE_HEIGHT    = 2'd1,
      CSR_REQUESTED_WIDTH  = 2'd2,
      CSR_REQUESTED_HEIGHT = 2'd3
   } csr_index_type;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_BAD_DIMS = 1'b1;

   // one result word as it sits in the queue
   typedef struct packed {
      logic [PIXEL_BITS-1:0] out_rgba;
      logic                  end_of_row;
      logic                  end_of_image;
      logic                  status;
   } rsp_word_type;

   // control from the register block to the front end
   typedef struct packed {
      logic restart;
      logic dims_invalid;
   } csr_ctrl_type;

endpackage

`default_nettype wire

/* sv/nnd_if.sv */
// Valid/ready channel interfaces for the pixel input and the result output.
// Depends on nnd_pkg for the payload widths.
`default_nettype none

interface nnd_req_if import nnd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] pixel_rgba;

   modport source (output valid, output pixel_rgba, input ready);
   modport sink   (input valid, input pixel_rgba, output ready);
endinterface

interface nnd_rsp_if import nnd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] out_rgba;
   logic                  end_of_row;
   logic                  end_of_image;
   logic                  status;

   modport source (output valid, output out_rgba, output end_of_row,
                   output end_of_image, output status, input ready);
   modport sink   (input valid, input out_rgba, input end_of_row,
                   input end_of_image, input status, output ready);
endinterface

`default_nettype wire

/* sv/nearest_neighbor_downscaler_unit.sv */
// Nearest-neighbor downscaler: an accepted pixel word's result is registered in the
// queue; throughput one pixel word per cycle while the queue is not full, set by
// the combinational add-and-compare pick in the front end. A 2-entry queue holds
// two result words while the output stalls; input stalls only once it is full.
// Synchronous active-high reset clears position state and the queue; registers
// reset to source 0x0 (every word reports bad dimensions) and request 1x1.
`default_nettype none

module nearest_neighbor_downscaler_unit import nnd_pkg::*; #(
   parameter int DIM_BITS = DEFAULT_DIM_BITS
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [DIM_BITS-1:0]       csr_write_data,
   nnd_req_if.sink                        req_in,
   nnd_rsp_if.source                      rsp_out
);

   logic [DIM_BITS-1:0] src_w, src_h, out_w, out_h;
   csr_ctrl_type        ctrl;
   logic                queue_full;
   logic                push;
   rsp_word_type        push_word;

   nnd_csr #(.DIM_BITS(DIM_BITS)) u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .src_w            (src_w),
      .src_h            (src_h),
      .out_w            (out_w),
      .out_h            (out_h),
      .ctrl             (ctrl)
   );

   nnd_front #(.DIM_BITS(DIM_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_in),
      .src_w      (src_w),
      .src_h      (src_h),
      .out_w      (out_w),
      .out_h      (out_h),
      .ctrl       (ctrl),
      .queue_full (queue_full),
      .push       (push),
      .push_word  (push_word)
   );

   nnd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .full      (queue_full),
      .rsp       (rsp_out)
   );

endmodule

`default_nettype wire

/* sv/nnd_csr.sv */
// Configuration registers and derived preview dimensions.
// Depends on nnd_pkg.
`default_nettype none

module nnd_csr import nnd_pkg::*; #(
   parameter int DIM_BITS = DEFAULT_DIM_BITS
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [DIM_BITS-1:0]       csr_write_data,
   output      logic [DIM_BITS-1:0]       src_w,
   output      logic [DIM_BITS-1:0]       src_h,
   output      logic [DIM_BITS-1:0]       out_w,
   output      logic [DIM_BITS-1:0]       out_h,
   output      csr_ctrl_type              ctrl
);

   logic [DIM_BITS-1:0] src_w_ff, src_h_ff, req_w_ff, req_h_ff;
   logic [DIM_BITS-1:0] src_w_in, src_h_in, req_w_in, req_h_in;
   logic [DIM_BITS-1:0] min_w, min_h;

   always_comb begin
      src_w_in = src_w_ff;
      src_h_in = src_h_ff;
      req_w_in = req_w_ff;
      req_h_in = req_h_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_SOURCE_WIDTH:     src_w_in = csr_write_data;
            CSR_SOURCE_HEIGHT:    src_h_in = csr_write_data;
            CSR_REQUESTED_WIDTH:  req_w_in = csr_write_data;
            CSR_REQUESTED_HEIGHT: req_h_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= '0;
         src_h_ff <= '0;
         req_w_ff <= DIM_BITS'(1);
         req_h_ff <= DIM_BITS'(1);
      end else begin
         src_w_ff <= src_w_in;
         src_h_ff <= src_h_in;
         req_w_ff <= req_w_in;
         req_h_ff <= req_h_in;
      end
   end

   // preview size: clamp requested to 1..source
   assign min_w = (req_w_ff < src_w_ff) ? req_w_ff : src_w_ff;
   assign min_h = (req_h_ff < src_h_ff) ? req_h_ff : src_h_ff;
   assign out_w = (min_w == '0) ? DIM_BITS'(1) : min_w;
   assign out_h = (min_h == '0) ? DIM_BITS'(1) : min_h;
   assign src_w = src_w_ff;
   assign src_h = src_h_ff;

   assign ctrl.restart      = csr_write_enable;
   assign ctrl.dims_invalid = (src_w_ff == '0) || (src_h_ff == '0);

endmodule

`default_nettype wire

/* sv/nnd_front.sv */
// Front end: takes source pixels, tracks raster position and decides picks
// with add-and-compare accumulators. Depends on nnd_pkg and nnd_if.
`default_nettype none

module nnd_front import nnd_pkg::*; #(
   parameter int DIM_BITS = DEFAULT_DIM_BITS
) (
   input  wire logic          clock,
   input  wire logic          reset,
   nnd_req_if.sink            req,
   input  wire logic [DIM_BITS-1:0] src_w,
   input  wire logic [DIM_BITS-1:0] src_h,
   input  wire logic [DIM_BITS-1:0] out_w,
   input  wire logic [DIM_BITS-1:0] out_h,
   input  wire csr_ctrl_type  ctrl,
   input  wire logic          queue_full,
   output      logic          push,
   output      rsp_word_type  push_word
);

   // holds index*size products plus one more size without overflow
   localparam int ACC_BITS = 2 * DIM_BITS + 1;
   localparam int EXT_BITS = ACC_BITS - DIM_BITS;

   logic [DIM_BITS-1:0] src_col_ff, src_row_ff, out_col_ff, out_row_ff;
   logic [DIM_BITS-1:0] src_col_in, src_row_in, out_col_in, out_row_in;
   logic [ACC_BITS-1:0] col_pick_ff, col_pass_ff, row_pick_ff, row_pass_ff;
   logic [ACC_BITS-1:0] col_pick_in, col_pass_in, row_pick_in, row_pass_in;
   logic [ACC_BITS-1:0] col_pass_next, row_pass_next;
   logic                accept, row_pick, col_pick, row_end, image_end;
   logic                eor;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;

   assign col_pass_next = col_pass_ff + {{EXT_BITS{1'b0}}, out_w};
   assign row_pass_next = row_pass_ff + {{EXT_BITS{1'b0}}, out_h};

   assign row_pick  = (out_row_ff < out_h) && (row_pick_ff < row_pass_next);
   assign col_pick  = (out_col_ff < out_w) && (col_pick_ff < col_pass_next);
   assign row_end   = src_col_ff >= (src_w - DIM_BITS'(1));
   assign image_end = row_end && (src_row_ff >= (src_h - DIM_BITS'(1)));
   assign eor       = out_col_ff == (out_w - DIM_BITS'(1));

   always_comb begin
      push_word.out_rgba     = '0;
      push_word.end_of_row   = 1'b0;
      push_word.end_of_image = 1'b0;
      push_word.status       = STATUS_BAD_DIMS;
      push = accept && (ctrl.dims_invalid || (row_pick && col_pick));
      if (!ctrl.dims_invalid) begin
         push_word.out_rgba     = req.pixel_rgba;
         push_word.end_of_row   = eor;
         push_word.end_of_image = eor && (out_row_ff == (out_h - DIM_BITS'(1)));
         push_word.status       = STATUS_OK;
      end
   end

   always_comb begin
      src_col_in  = src_col_ff;
      src_row_in  = src_row_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      col_pick_in = col_pick_ff;
      col_pass_in = col_pass_ff;
      row_pick_in = row_pick_ff;
      row_pass_in = row_pass_ff;
      if (ctrl.restart || (accept && !ctrl.dims_invalid && image_end)) begin
         src_col_in  = '0;
         src_row_in  = '0;
         out_col_in  = '0;
         out_row_in  = '0;
         col_pick_in = '0;
         col_pass_in = '0;
         row_pick_in = '0;
         row_pass_in = '0;
      end else if (accept && !ctrl.dims_invalid) begin
         if (row_end) begin
            src_col_in  = '0;
            src_row_in  = src_row_ff + DIM_BITS'(1);
            out_col_in  = '0;
            col_pick_in = '0;
            col_pass_in = '0;
            row_pass_in = row_pass_next;
            if (row_pick) begin
               out_row_in  = out_row_ff + DIM_BITS'(1);
               row_pick_in = row_pick_ff + {{EXT_BITS{1'b0}}, src_h};
            end
         end else begin
            src_col_in  = src_col_ff + DIM_BITS'(1);
            col_pass_in = col_pass_next;
            if (row_pick && col_pick) begin
               out_col_in  = out_col_ff + DIM_BITS'(1);
               col_pick_in = col_pick_ff + {{EXT_BITS{1'b0}}, src_w};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_col_ff  <= '0;
         src_row_ff  <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         col_pick_ff <= '0;
         col_pass_ff <= '0;
         row_pick_ff <= '0;
         row_pass_ff <= '0;
      end else begin
         src_col_ff  <= src_col_in;
         src_row_ff  <= src_row_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         col_pick_ff <= col_pick_in;
         col_pass_ff <= col_pass_in;
         row_pick_ff <= row_pick_in;
         row_pass_ff <= row_pass_in;
      end
   end

   a_src_col_in_row: assert property (@(posedge clock) disable iff (reset)
      !ctrl.dims_invalid |-> (src_col_ff < src_w))
      else $error("source column ran past source width");

   a_out_col_bound: assert property (@(posedge clock) disable iff (reset)
      !ctrl.dims_invalid |-> (out_col_ff <= out_w))
      else $error("preview column ran past preview width");

   a_out_row_bound: assert property (@(posedge clock) disable iff (reset)
      !ctrl.dims_invalid |-> (out_row_ff <= out_h))
      else $error("preview row ran past preview height");

   a_bad_dims_word: assert property (@(posedge clock) disable iff (reset)
      (accept && ctrl.dims_invalid) |-> push)
      else $error("word with bad dimensions produced no result");

endmodule

`default_nettype wire

/* sv/nnd_queue.sv */
// Short result queue between the front end and the output channel.
// Registered entries and count; depends on nnd_pkg and nnd_if.
`default_nettype none

module nnd_queue import nnd_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire rsp_word_type push_word,
   output      logic         full,
   nnd_rsp_if.source         rsp
);

   localparam int PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   rsp_word_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, rd_ptr_ff, wr_ptr_in, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  pop;
   rsp_word_type          head;

   assign pop  = rsp.valid && rsp.ready;
   assign full = count_ff == COUNT_BITS'(QUEUE_DEPTH);
   assign head = entry_ff[rd_ptr_ff];

   assign rsp.valid        = count_ff != '0;
   assign rsp.out_rgba     = head.out_rgba;
   assign rsp.end_of_row   = head.end_of_row;
   assign rsp.end_of_image = head.end_of_image;
   assign rsp.status       = head.status;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                             : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                             : rd_ptr_ff + PTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(QUEUE_DEPTH))
      else $error("queue count out of range");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + COUNT_BITS'(1)))
      else $error("queue count missed a push");

endmodule

`default_nettype wire
